/* src/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Scan modes, result kinds, error codes, the decoded-result record that
// travels from the front end to the back end, and the small decode and encode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Input commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// Result queue depth, power of two
	localparam int QDEPTH = 4;

	// Surrogate ranges and the supplementary plane base
	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_USUAL  = 4'd1,
		M_ESC    = 4'd2,
		M_HEX1   = 4'd3,
		M_HEX2   = 4'd4,
		M_HEX3   = 4'd5,
		M_HEX4   = 4'd6,
		M_EXP_BS = 4'd7,
		M_EXP_U  = 4'd8,
		M_LHEX1  = 4'd9,
		M_LHEX2  = 4'd10,
		M_LHEX3  = 4'd11,
		M_LHEX4  = 4'd12
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_CTRL   = 3'd0,
		ERR_ESC    = 3'd1,
		ERR_HEX    = 3'd2,
		ERR_SINGLE = 3'd3,
		ERR_PAIR   = 3'd4,
		ERR_LONG   = 3'd5,
		ERR_UNTERM = 3'd6
	} err_t;

	// UTF-8 sequence: bytes[0] goes out first, last_idx is length minus one
	typedef struct packed {
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} utf8_t;

	// One queue entry: all results caused by one input transfer
	typedef struct packed {
		kind_t           kind;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
		err_t            err;
		logic [23:0]     len;
	} job_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			r = {1'b1, ch[3:0]};
		end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
			r = {1'b1, ch[3:0] + 4'd9};
		end
		return r;
	endfunction

	// {valid, byte} for the one-character escapes other than \u
	function automatic logic [8:0] esc_decode(input logic [7:0] ch);
		logic [8:0] r;
		r = 9'd0;
		unique case (ch)
			8'h22, 8'h5C, 8'h2F: r = {1'b1, ch};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.last_idx = 2'd0;
			r.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.last_idx = 2'd1;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.last_idx = 2'd2;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.last_idx = 2'd3;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

/* src/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string body decoder
//
//   channel   signals                                   direction
//   input     in_valid/in_stall, cmd, data_byte         in  (stall out)
//   result    out_valid/out_stall, kind, out_byte,      out (stall in)
//             error_code, decoded_length, last
//   config    cfg_we, cfg_wdata (max_length)            in, no wait
//
// One input transfer per cycle while the result queue is not full. The
// front end scans each byte and queues at most one entry; the back end sends
// that entry's one to four results at one per cycle, while the receiver does
// not stall, from an output register. A \uXXXX escape spends six input bytes
// on at most three results, a pair twelve on four; plain bytes right behind
// a pair meet a stall while its four results hold the head entry. Each
// result is registered in the queue and then in the output register. Reset
// clears the scanner, counters, queue and output register; max_length resets
// to all ones. in_stall rises only while the four-entry queue is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  error_code,
	output logic [23:0] decoded_length,
	output logic        last,
	// configuration
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	logic          in_fire;
	logic          q_push, q_pop, q_full, q_empty;
	jsu_pkg::job_t q_wdata, q_head;
	logic [23:0]   max_length_q;

	// max_length register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= 24'hFFFFFF;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// Input is held off only by a full queue
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	jsu_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.max_length (max_length_q),
		.push       (q_push),
		.job        (q_wdata)
	);

	// Decouples scanning from result delivery
	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	// Splits each entry into result transfers, last flag on the final one
	jsu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.empty          (q_empty),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.out_byte       (out_byte),
		.error_code     (error_code),
		.decoded_length (decoded_length),
		.last           (last)
	);

	// ---- assertions ----
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty)) else $error("queue pop while empty");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == jsu_pkg::CMD_START) |-> !q_push)
		else $error("start command produced a result");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != jsu_pkg::KIND_BYTE) |-> last)
		else $error("done or error result without last");

endmodule

/* src/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: scanner front end
// Runs the escape scanner on each accepted input and builds one queue entry
// per input that causes results.
// ----------------------------------------------------------------------------
module jsu_front #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [1:0]     cmd,
	input  logic [7:0]     data_byte,
	input  logic [23:0]    max_length,
	output logic           push,
	output jsu_pkg::job_t  job
);

	localparam int LW = ((COUNT_WIDTH > 24) ? COUNT_WIDTH : 24) + 2;

	jsu_pkg::mode_t           mode_q, mode_d;
	logic [15:0]              cu_q, cu_d;
	logic [15:0]              hs_q, hs_d;
	logic [COUNT_WIDTH-1:0]   est_q, est_d;
	logic [COUNT_WIDTH-1:0]   ocnt_q, ocnt_d;

	logic [4:0]               hex_r;
	logic [8:0]               esc_r;
	logic [15:0]              cu_new;
	logic                     last_hex;
	logic [LW-1:0]            lim_w, mask_w, next_w;
	logic                     grow_ok;
	logic                     is_hi, is_lo;
	logic [20:0]              cp;
	jsu_pkg::utf8_t           enc;

	assign hex_r    = jsu_pkg::hex_decode(data_byte);
	assign esc_r    = jsu_pkg::esc_decode(data_byte);
	assign cu_new   = {cu_q[11:0], hex_r[3:0]};
	assign last_hex = (mode_q == jsu_pkg::M_HEX4) || (mode_q == jsu_pkg::M_LHEX4);

	// Length estimate: +3 per \u unit, +1 otherwise; limit capped by counter width
	assign mask_w  = (LW'(1) << COUNT_WIDTH) - LW'(1);
	assign lim_w   = (LW'(max_length) > mask_w) ? mask_w : LW'(max_length);
	assign next_w  = LW'(est_q) + (last_hex ? LW'(3) : LW'(1));
	assign grow_ok = (next_w <= lim_w);

	assign is_hi = (cu_new >= jsu_pkg::HI_SURR_MIN) && (cu_new <= jsu_pkg::HI_SURR_MAX);
	assign is_lo = (cu_new >= jsu_pkg::LO_SURR_MIN) && (cu_new <= jsu_pkg::LO_SURR_MAX);

	assign cp  = (mode_q == jsu_pkg::M_LHEX4) ?
		(21'({hs_q[9:0], cu_new[9:0]}) + jsu_pkg::SUPP_BASE) : 21'(cu_new);
	assign enc = jsu_pkg::utf8_encode(cp);

	// Next scan mode
	always_comb begin
		mode_d = mode_q;
		if (fire) begin
			priority if (cmd == jsu_pkg::CMD_START) begin
				mode_d = jsu_pkg::M_USUAL;
			end else if (cmd == jsu_pkg::CMD_END) begin
				mode_d = jsu_pkg::M_IDLE;
			end else if (cmd == jsu_pkg::CMD_BYTE) begin
				unique case (mode_q)
					jsu_pkg::M_IDLE: mode_d = jsu_pkg::M_IDLE;
					jsu_pkg::M_USUAL: begin
						priority if (data_byte == 8'h22) mode_d = jsu_pkg::M_IDLE;
						else if (data_byte == 8'h5C) mode_d = jsu_pkg::M_ESC;
						else if (data_byte < 8'h20) mode_d = jsu_pkg::M_IDLE;
						else if (!grow_ok) mode_d = jsu_pkg::M_IDLE;
						else mode_d = jsu_pkg::M_USUAL;
					end
					jsu_pkg::M_ESC: begin
						priority if (data_byte == 8'h75) mode_d = jsu_pkg::M_HEX1;
						else if (esc_r[8] && grow_ok) mode_d = jsu_pkg::M_USUAL;
						else mode_d = jsu_pkg::M_IDLE;
					end
					jsu_pkg::M_EXP_BS:
						mode_d = (data_byte == 8'h5C) ? jsu_pkg::M_EXP_U : jsu_pkg::M_IDLE;
					jsu_pkg::M_EXP_U:
						mode_d = (data_byte == 8'h75) ? jsu_pkg::M_LHEX1 : jsu_pkg::M_IDLE;
					jsu_pkg::M_HEX1: mode_d = hex_r[4] ? jsu_pkg::M_HEX2 : jsu_pkg::M_IDLE;
					jsu_pkg::M_HEX2: mode_d = hex_r[4] ? jsu_pkg::M_HEX3 : jsu_pkg::M_IDLE;
					jsu_pkg::M_HEX3: mode_d = hex_r[4] ? jsu_pkg::M_HEX4 : jsu_pkg::M_IDLE;
					jsu_pkg::M_LHEX1: mode_d = hex_r[4] ? jsu_pkg::M_LHEX2 : jsu_pkg::M_IDLE;
					jsu_pkg::M_LHEX2: mode_d = hex_r[4] ? jsu_pkg::M_LHEX3 : jsu_pkg::M_IDLE;
					jsu_pkg::M_LHEX3: mode_d = hex_r[4] ? jsu_pkg::M_LHEX4 : jsu_pkg::M_IDLE;
					jsu_pkg::M_HEX4: begin
						priority if (!hex_r[4] || !grow_ok) mode_d = jsu_pkg::M_IDLE;
						else if (is_hi) mode_d = jsu_pkg::M_EXP_BS;
						else if (is_lo) mode_d = jsu_pkg::M_IDLE;
						else mode_d = jsu_pkg::M_USUAL;
					end
					jsu_pkg::M_LHEX4: begin
						mode_d = (hex_r[4] && grow_ok && is_lo) ?
							jsu_pkg::M_USUAL : jsu_pkg::M_IDLE;
					end
					default: mode_d = jsu_pkg::M_IDLE;
				endcase
			end else begin
				mode_d = mode_q;
			end
		end
	end

	// Queue entry and datapath updates
	always_comb begin
		push   = 1'b0;
		job    = '0;
		cu_d   = cu_q;
		hs_d   = hs_q;
		est_d  = est_q;
		ocnt_d = ocnt_q;
		if (fire) begin
			priority if (cmd == jsu_pkg::CMD_START) begin
				est_d  = '0;
				ocnt_d = '0;
			end else if (cmd == jsu_pkg::CMD_END) begin
				if (mode_q != jsu_pkg::M_IDLE) begin
					push     = 1'b1;
					job.kind = jsu_pkg::KIND_ERR;
					job.err  = jsu_pkg::ERR_UNTERM;
				end
			end else if (cmd == jsu_pkg::CMD_BYTE) begin
				unique case (mode_q)
					jsu_pkg::M_IDLE: push = 1'b0;
					jsu_pkg::M_USUAL: begin
						priority if (data_byte == 8'h22) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_DONE;
							job.len  = 24'(ocnt_q);
						end else if (data_byte == 8'h5C) begin
							push = 1'b0;
						end else if (data_byte < 8'h20) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_CTRL;
						end else if (!grow_ok) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_LONG;
						end else begin
							push         = 1'b1;
							job.kind     = jsu_pkg::KIND_BYTE;
							job.bytes[0] = data_byte;
							est_d        = next_w[COUNT_WIDTH-1:0];
							ocnt_d       = ocnt_q + COUNT_WIDTH'(1);
						end
					end
					jsu_pkg::M_ESC: begin
						priority if (data_byte == 8'h75) begin
							push = 1'b0;
						end else if (!esc_r[8]) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_ESC;
						end else if (!grow_ok) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_LONG;
						end else begin
							push         = 1'b1;
							job.kind     = jsu_pkg::KIND_BYTE;
							job.bytes[0] = esc_r[7:0];
							est_d        = next_w[COUNT_WIDTH-1:0];
							ocnt_d       = ocnt_q + COUNT_WIDTH'(1);
						end
					end
					jsu_pkg::M_EXP_BS, jsu_pkg::M_EXP_U: begin
						if ((mode_q == jsu_pkg::M_EXP_BS && data_byte != 8'h5C) ||
						    (mode_q == jsu_pkg::M_EXP_U && data_byte != 8'h75)) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_SINGLE;
						end
					end
					jsu_pkg::M_HEX1, jsu_pkg::M_HEX2, jsu_pkg::M_HEX3, jsu_pkg::M_HEX4,
					jsu_pkg::M_LHEX1, jsu_pkg::M_LHEX2, jsu_pkg::M_LHEX3,
					jsu_pkg::M_LHEX4: begin
						priority if (!hex_r[4]) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_HEX;
						end else if (!last_hex) begin
							cu_d = cu_new;
						end else if (!grow_ok) begin
							push     = 1'b1;
							job.kind = jsu_pkg::KIND_ERR;
							job.err  = jsu_pkg::ERR_LONG;
						end else begin
							cu_d  = cu_new;
							est_d = next_w[COUNT_WIDTH-1:0];
							priority if (mode_q == jsu_pkg::M_LHEX4 && !is_lo) begin
								push     = 1'b1;
								job.kind = jsu_pkg::KIND_ERR;
								job.err  = jsu_pkg::ERR_PAIR;
							end else if (mode_q == jsu_pkg::M_HEX4 && is_hi) begin
								hs_d = cu_new;
							end else if (mode_q == jsu_pkg::M_HEX4 && is_lo) begin
								push     = 1'b1;
								job.kind = jsu_pkg::KIND_ERR;
								job.err  = jsu_pkg::ERR_SINGLE;
							end else begin
								push         = 1'b1;
								job.kind     = jsu_pkg::KIND_BYTE;
								job.last_idx = enc.last_idx;
								job.bytes    = enc.bytes;
								ocnt_d       = ocnt_q + COUNT_WIDTH'(enc.last_idx)
								             + COUNT_WIDTH'(1);
							end
						end
					end
					default: push = 1'b0;
				endcase
			end else begin
				push = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::M_IDLE;
			est_q  <= '0;
			ocnt_q <= '0;
		end else begin
			mode_q <= mode_d;
			est_q  <= est_d;
			ocnt_q <= ocnt_d;
		end
	end

	// code unit and surrogate are always written before they are read
	always_ff @(posedge clk) begin
		cu_q <= cu_d;
		hs_q <= hs_d;
	end

endmodule

/* src/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue: result queue between front and back
// Small show-ahead FIFO of queue entries.
// ----------------------------------------------------------------------------
module jsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output jsu_pkg::job_t head,
	output logic          empty
);

	localparam int AW = $clog2(jsu_pkg::QDEPTH);

	jsu_pkg::job_t  entry_q [jsu_pkg::QDEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(jsu_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: result sequencer
// Walks the head entry into the output register one result per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [7:0]    out_byte,
	output logic [2:0]    error_code,
	output logic [23:0]   decoded_length,
	output logic          last
);

	logic [1:0]  idx_q;
	logic        ov_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [2:0]  err_q;
	logic [23:0] len_q;
	logic        last_q;
	logic        load;
	logic        item_last;

	assign load      = !ov_q || !out_stall;
	assign item_last = (head.kind != jsu_pkg::KIND_BYTE) || (idx_q == head.last_idx);
	assign pop       = load && !empty && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			ov_q <= !empty;
			if (!empty) begin
				idx_q <= item_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q <= head.kind;
			byte_q <= head.bytes[idx_q];
			err_q  <= head.err;
			len_q  <= head.len;
			last_q <= item_last;
		end
	end

	assign out_valid      = ov_q;
	assign kind           = kind_q;
	assign out_byte       = byte_q;
	assign error_code     = err_q;
	assign decoded_length = len_q;
	assign last           = last_q;

endmodule

/* tb/json_string_unescape_utf8_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking bench for the JSON string decoder
// Feeds start/body/end commands through a bursty driver, predicts every
// decoded byte, done and error result in a behavioral decoder, and checks
// each result transfer against the oldest prediction. Covers several
// max_length settings, surrogate pairs and every error path.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// cmd 3 has no meaning; the block must ignore it
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int SETTLE_CYCLES = 8;       // covers the front end, small queue and output register
	localparam int HOLD_CYCLES   = 150;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 60;      // keep the log short on a bad build

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] data;
	} item_t;

	typedef struct {
		jsu_pkg::kind_t kind;
		logic [7:0]     data;
		logic [2:0]     code;
		logic [23:0]    len;
		logic           last;
	} res_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = jsu_pkg::CMD_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [2:0]  error_code;
	logic [23:0] decoded_length;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;

	json_string_unescape_utf8 u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.out_byte       (out_byte),
		.error_code     (error_code),
		.decoded_length (decoded_length),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Bench state shared between the processes
	// ------------------------------------------------------------------------
	item_t pending_q[$];        // items waiting for the driver
	res_t  expected_q[$];       // predicted results, oldest first
	int    stim_total = 0;      // counted stimulus items (idle noise excluded)
	int    fail_cnt = 0;
	int    gap_style = 1;       // 0: back-to-back, 1: random bursts and gaps
	int    stall_style = 1;     // receiver pattern, see the receiver block
	int    hold_req = 0;        // bump to ask the receiver for a long hold-off

	// ------------------------------------------------------------------------
	// Behavioral decoder: shadow state, updated at every accepted input
	// ------------------------------------------------------------------------
	jsu_pkg::mode_t scan_st = jsu_pkg::M_IDLE;
	logic [15:0]    unit_acc = '0;
	logic [15:0]    hi_unit = '0;
	int             est_len = 0;
	logic [23:0]    out_len = '0;
	logic [23:0]    max_len = 24'hFFFFFF;

	task automatic push_res(input jsu_pkg::kind_t k, input logic [7:0] d,
	                        input logic [2:0] e, input logic [23:0] l);
		res_t r;
		r.kind = k;
		r.data = d;
		r.code = e;
		r.len  = l;
		r.last = 1'b0;
		expected_q.push_back(r);
	endtask

	// Any error closes the string
	task automatic raise_err(input jsu_pkg::err_t e);
		scan_st = jsu_pkg::M_IDLE;
		push_res(jsu_pkg::KIND_ERR, '0, e, '0);
	endtask

	task automatic put_byte(input logic [7:0] d);
		out_len = out_len + 24'd1;
		push_res(jsu_pkg::KIND_BYTE, d, '0, '0);
	endtask

	// Length estimate: +1 per plain byte or simple escape, +3 per \u unit
	function automatic bit grow_estimate(input int amount);
		if (est_len + amount > int'(max_len)) return 1'b0;
		est_len = est_len + amount;
		return 1'b1;
	endfunction

	function automatic int hex_nibble(input logic [7:0] ch);
		if (ch >= "0" && ch <= "9") return int'(ch - 8'h30);
		if (ch >= "A" && ch <= "F") return int'(ch - 8'h37);
		if (ch >= "a" && ch <= "f") return int'(ch - 8'h57);
		return -1;
	endfunction

	task automatic put_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
		scan_st = jsu_pkg::M_USUAL;
	endtask

	task automatic decode_body(input logic [7:0] ch);
		logic [7:0]  esc;
		logic [20:0] cp;
		int          nib;
		case (scan_st)
			jsu_pkg::M_IDLE: begin
				// no open string: dropped
			end
			jsu_pkg::M_USUAL: begin
				if (ch == CH_QUOTE) begin
					scan_st = jsu_pkg::M_IDLE;
					push_res(jsu_pkg::KIND_DONE, '0, '0, out_len);
				end else if (ch == CH_BSLASH) begin
					scan_st = jsu_pkg::M_ESC;
				end else if (ch < CH_SPACE) begin
					raise_err(jsu_pkg::ERR_CTRL);
				end else if (!grow_estimate(1)) begin
					raise_err(jsu_pkg::ERR_LONG);
				end else begin
					put_byte(ch);
				end
			end
			jsu_pkg::M_ESC: begin
				esc = ch;
				case (ch)
					CH_QUOTE, CH_BSLASH, CH_SLASH: esc = ch;
					"n": esc = 8'h0A;
					"r": esc = 8'h0D;
					"t": esc = 8'h09;
					"b": esc = 8'h08;
					"f": esc = 8'h0C;
					CH_U: begin
						unit_acc = '0;
						scan_st = jsu_pkg::M_HEX1;
						return;
					end
					default: begin
						raise_err(jsu_pkg::ERR_ESC);
						return;
					end
				endcase
				if (!grow_estimate(1)) begin
					raise_err(jsu_pkg::ERR_LONG);
				end else begin
					scan_st = jsu_pkg::M_USUAL;
					put_byte(esc);
				end
			end
			jsu_pkg::M_EXP_BS: begin
				if (ch != CH_BSLASH) raise_err(jsu_pkg::ERR_SINGLE);
				else scan_st = jsu_pkg::M_EXP_U;
			end
			jsu_pkg::M_EXP_U: begin
				if (ch != CH_U) begin
					raise_err(jsu_pkg::ERR_SINGLE);
				end else begin
					unit_acc = '0;
					scan_st = jsu_pkg::M_LHEX1;
				end
			end
			default: begin
				// one of the eight hex digit states
				nib = hex_nibble(ch);
				if (nib < 0) begin
					raise_err(jsu_pkg::ERR_HEX);
				end else begin
					unit_acc = {unit_acc[11:0], nib[3:0]};
					if (scan_st != jsu_pkg::M_HEX4 && scan_st != jsu_pkg::M_LHEX4) begin
						scan_st = jsu_pkg::mode_t'(scan_st + 4'd1);
					end else if (!grow_estimate(3)) begin
						// length goes before any surrogate check
						raise_err(jsu_pkg::ERR_LONG);
					end else if (scan_st == jsu_pkg::M_LHEX4) begin
						if (unit_acc < jsu_pkg::LO_SURR_MIN ||
						    unit_acc > jsu_pkg::LO_SURR_MAX) begin
							raise_err(jsu_pkg::ERR_PAIR);
						end else begin
							// both units sit in their ranges, so the offsets
							// are their low ten bits
							cp = {1'b0, hi_unit[9:0], unit_acc[9:0]} + jsu_pkg::SUPP_BASE;
							put_code_point(cp);
						end
					end else if (unit_acc < jsu_pkg::HI_SURR_MIN ||
					             unit_acc > jsu_pkg::LO_SURR_MAX) begin
						put_code_point({5'd0, unit_acc});
					end else if (unit_acc > jsu_pkg::HI_SURR_MAX) begin
						raise_err(jsu_pkg::ERR_SINGLE);
					end else begin
						hi_unit = unit_acc;
						scan_st = jsu_pkg::M_EXP_BS;
					end
				end
			end
		endcase
	endtask

	task automatic predict_item(input logic [1:0] c, input logic [7:0] ch);
		int n0;
		n0 = expected_q.size();
		case (c)
			jsu_pkg::CMD_START: begin
				// also drops an open string silently
				scan_st  = jsu_pkg::M_USUAL;
				unit_acc = '0;
				hi_unit  = '0;
				est_len  = 0;
				out_len  = '0;
			end
			jsu_pkg::CMD_END: begin
				if (scan_st != jsu_pkg::M_IDLE) raise_err(jsu_pkg::ERR_UNTERM);
			end
			jsu_pkg::CMD_BYTE: decode_body(ch);
			default: begin
				// spare command: ignored
			end
		endcase
		if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Driver: bursts of random length, with random gaps unless gap_style is 0.
	// A stalled transfer holds its payload; prediction happens at the accepting edge.
	// ------------------------------------------------------------------------
	int gap_left = 0;
	int burst_left = 0;

	always @(posedge clk) begin : driver
		item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_item(cmd, data_byte);
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q.pop_front();
					in_valid  <= 1'b1;
					cmd       <= nxt.cmd;
					data_byte <= nxt.data;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = (gap_style != 0) ? $urandom_range(1, 5) : 0;
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall pattern per phase, plus a long hold-off on request
	// ------------------------------------------------------------------------
	int hold_seen = 0;
	int hold_left = 0;
	int pat_cnt = 0;

	always @(posedge clk) begin : receiver
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 75);
				default: out_stall <= ((pat_cnt % 5) < 3);
			endcase
		end
		pat_cnt = pat_cnt + 1;
	end

	// ------------------------------------------------------------------------
	// Monitor: every result transfer against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				fail_cnt = fail_cnt + 1;
				if (fail_cnt <= REPORT_LIMIT)
					$display({"%0t: unexpected result, expected none, ",
					          "got kind=%0d byte=%02h code=%0d len=%0d last=%0d"},
					         $time, kind, out_byte, error_code, decoded_length, last);
			end else begin
				want = expected_q.pop_front();
				if (kind !== want.kind || out_byte !== want.data ||
				    error_code !== want.code ||
				    decoded_length !== want.len || last !== want.last) begin
					fail_cnt = fail_cnt + 1;
					if (fail_cnt <= REPORT_LIMIT)
						$display({"%0t: mismatch, expected kind=%0d byte=%02h code=%0d ",
						          "len=%0d last=%0d, got kind=%0d byte=%02h code=%0d ",
						          "len=%0d last=%0d"},
						         $time, want.kind, want.data, want.code, want.len,
						         want.last, kind, out_byte, error_code,
						         decoded_length, last);
				end
			end
		end
	end

	// Watchdog
	int cycle_cnt = 0;

	always @(posedge clk) begin : watchdog
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_item(input logic [1:0] c, input logic [7:0] d);
		item_t it;
		it.cmd  = c;
		it.data = d;
		pending_q.push_back(it);
		stim_total = stim_total + 1;
	endtask

	// Bytes and end commands between strings, dropped unless the string was left open;
	// not counted as stimulus
	task automatic push_noise();
		item_t it;
		it.cmd  = ($urandom_range(0, 2) == 0) ? jsu_pkg::CMD_END : jsu_pkg::CMD_BYTE;
		it.data = 8'($urandom_range(0, 255));
		pending_q.push_back(it);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'd0, n};
		return (($urandom_range(0, 1) != 0) ? 8'h37 : 8'h57) + {4'd0, n};
	endfunction

	task automatic push_unit(input logic [15:0] u);
		push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
		push_item(jsu_pkg::CMD_BYTE, CH_U);
		for (int i = 3; i >= 0; i--) push_item(jsu_pkg::CMD_BYTE, hex_char(u[i*4 +: 4]));
	endtask

	function automatic bit is_escape_char(input logic [7:0] ch);
		return ch == CH_QUOTE || ch == CH_BSLASH || ch == CH_SLASH || ch == CH_U ||
		       ch == "n" || ch == "r" || ch == "t" || ch == "b" || ch == "f";
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h80, 8'hFF));
		do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [15:0] rand_high();
		return 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
	endfunction

	function automatic logic [15:0] rand_low();
		return 16'($urandom_range(jsu_pkg::LO_SURR_MIN, jsu_pkg::LO_SURR_MAX));
	endfunction

	function automatic logic [15:0] rand_bmp();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hD7FF));
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	// One string: mostly well formed, sometimes ending in a fault
	task automatic gen_string();
		logic [7:0]  b;
		logic [15:0] u;
		int          k;
		push_item(jsu_pkg::CMD_START, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 8)) begin
			k = $urandom_range(0, 99);
			if (k < 40) begin
				push_item(jsu_pkg::CMD_BYTE, plain_byte());
			end else if (k < 60) begin
				push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
				case ($urandom_range(0, 7))
					0: b = CH_QUOTE;
					1: b = CH_BSLASH;
					2: b = CH_SLASH;
					3: b = "n";
					4: b = "r";
					5: b = "t";
					6: b = "b";
					default: b = "f";
				endcase
				push_item(jsu_pkg::CMD_BYTE, b);
			end else if (k < 80) begin
				push_unit(rand_bmp());
			end else begin
				push_unit(rand_high());
				push_unit(rand_low());
			end
		end
		if ($urandom_range(0, 99) < 80) begin
			push_item(jsu_pkg::CMD_BYTE, CH_QUOTE);
		end else begin
			case ($urandom_range(0, 10))
				0: push_item(jsu_pkg::CMD_BYTE, 8'($urandom_range(0, 8'h1F)));
				1: begin
					push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
					do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
					push_item(jsu_pkg::CMD_BYTE, b);
				end
				2: begin
					// bad digit in a first or a second unit
					if ($urandom_range(0, 1) != 0) push_unit(rand_high());
					push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
					push_item(jsu_pkg::CMD_BYTE, CH_U);
					repeat ($urandom_range(0, 3))
						push_item(jsu_pkg::CMD_BYTE, hex_char(4'($urandom_range(0, 15))));
					do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
					push_item(jsu_pkg::CMD_BYTE, b);
				end
				3: push_unit(rand_low());
				4: begin
					// high unit not followed by a backslash
					push_unit(rand_high());
					if ($urandom_range(0, 1) != 0) b = CH_QUOTE;
					else do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
					push_item(jsu_pkg::CMD_BYTE, b);
				end
				5: begin
					push_unit(rand_high());
					push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
					do b = 8'($urandom_range(0, 255)); while (b == CH_U);
					push_item(jsu_pkg::CMD_BYTE, b);
				end
				6: begin
					push_unit(rand_high());
					do u = 16'($urandom_range(0, 16'hFFFF));
					while (u >= jsu_pkg::LO_SURR_MIN && u <= jsu_pkg::LO_SURR_MAX);
					push_unit(u);
				end
				7: push_item(jsu_pkg::CMD_END, 8'($urandom_range(0, 255)));
				8: begin
					// restart in the middle of a string
					push_item(jsu_pkg::CMD_START, 8'($urandom_range(0, 255)));
					push_item(jsu_pkg::CMD_BYTE, plain_byte());
					push_item(jsu_pkg::CMD_BYTE, CH_QUOTE);
				end
				9: begin
					push_item(CMD_SPARE, 8'($urandom_range(0, 255)));
					push_item(jsu_pkg::CMD_BYTE, CH_QUOTE);
				end
				default: begin
					// left open; noise may close it, else the next start drops it
				end
			endcase
		end
		repeat ($urandom_range(0, 2)) push_noise();
	endtask

	task automatic gen_strings(input int count);
		int goal;
		goal = stim_total + count;
		while (stim_total < goal) gen_string();
	endtask

	// Sender side pause: everything sent and every result back. Checked at
	// the falling edge, after the driver and monitor have settled.
	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(negedge clk);
	endtask

	// Register write only while the decoder is quiet
	task automatic write_max_len(input logic [23:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_len = v;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset limit: idle drops, widest \u output, control, escape and unterminated errors
		push_item(jsu_pkg::CMD_BYTE, 8'h78);        // no string open yet
		push_item(jsu_pkg::CMD_END, 8'h00);         // idle end of payload
		push_item(CMD_SPARE, 8'hA5);
		push_item(jsu_pkg::CMD_START, 8'h00);
		push_item(jsu_pkg::CMD_BYTE, CH_SPACE);     // lowest plain byte
		push_item(jsu_pkg::CMD_BYTE, 8'hFF);        // high bytes pass through
		push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
		push_item(jsu_pkg::CMD_BYTE, CH_U);
		push_item(jsu_pkg::CMD_BYTE, "F");
		push_item(jsu_pkg::CMD_BYTE, "f");
		push_item(jsu_pkg::CMD_BYTE, "f");
		push_item(jsu_pkg::CMD_BYTE, "F");          // U+FFFF, three bytes
		push_item(jsu_pkg::CMD_BYTE, CH_QUOTE);     // done, length 5
		push_item(jsu_pkg::CMD_START, 8'hFF);
		push_item(jsu_pkg::CMD_BYTE, 8'h1F);        // control byte
		push_item(jsu_pkg::CMD_START, 8'h00);
		push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
		push_item(jsu_pkg::CMD_BYTE, "q");          // bad escape
		push_item(jsu_pkg::CMD_START, 8'h00);
		push_item(jsu_pkg::CMD_BYTE, CH_BSLASH);
		push_item(jsu_pkg::CMD_BYTE, CH_QUOTE);
		push_item(jsu_pkg::CMD_START, 8'h00);       // restart drops the open string
		push_item(jsu_pkg::CMD_END, 8'h00);         // unterminated
		push_item(jsu_pkg::CMD_END, 8'h00);         // already closed: dropped

		// Zero limit: only empty strings survive
		write_max_len(24'h000000);
		gen_strings(10);

		// Widest limit, random bursts; sender pauses halfway for a full drain
		write_max_len(24'hFFFFFF);
		gen_strings(30);
		wait_drained();
		gen_strings(30);

		// Tight limit, heavy receiver stall
		write_max_len(24'd9);
		stall_style = 2;
		gen_strings(35);

		// Long receiver hold-off while the sender streams back to back,
		// so the result queue fills and the input stalls
		write_max_len(24'($urandom_range(20, 200)));
		gap_style = 0;
		stall_style = 0;
		hold_req = hold_req + 1;
		gen_strings(40);

		// Near the top of the range: fixed stall pattern with no sender gaps, then random gaps and stalls
		write_max_len(24'hFFFFFE);
		stall_style = 3;
		gen_strings(30);
		gap_style = 1;
		stall_style = 1;
		gen_strings(30);

		wait_drained();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
